// ===== hw/rtl/sbd_pkg.sv =====
// Shared types and constants for the spectral beat detector.
// Used by every module of the block but sbd_ram; depends on nothing.
`default_nettype none

package sbd_pkg;

    localparam int NUM_BANDS_DEF = 32;
    localparam int LVL_W         = 16;
    localparam int PHASE_W       = 17;
    localparam int ENTRY_W       = PHASE_W + 2 * LVL_W;
    localparam int MASK_W        = 32;
    localparam int CNT_W         = 6;
    localparam int SUM_W         = 21;
    localparam int DSTEP_W       = $clog2(SUM_W);
    localparam int HOLD_W        = 8;
    localparam int PROD_W        = 2 * PHASE_W;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [PHASE_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [LVL_W-1:0]  DECAY_STEP_RST     = 16'd9175;
    localparam logic [LVL_W-1:0]  BEAT_THRESHOLD_RST = 16'd26214;
    localparam logic [HOLD_W-1:0] HOLDOFF_COUNT_RST  = 8'd5;
    localparam logic [MASK_W-1:0] BAND_ENABLE_RST    = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY_STEP     = 2'd0,
        CFG_BEAT_THRESHOLD = 2'd1,
        CFG_HOLDOFF_COUNT  = 2'd2,
        CFG_BAND_ENABLE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_SQ,
        MUL_CUBE,
        MUL_SCALE
    } t_mul_sel;

    typedef struct packed {
        logic     accept;
        logic     load_entry;
        logic     capture;
        t_mul_sel mul;
        logic     write_decay;
        logic     accumulate;
        logic     div_start;
        logic     div_step;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic bigger;
        logic phase_full;
        logic last;
        logic count_zero;
        logic div_last;
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/spectral_beat_detector.sv =====
// Spectral beat detector, top level: joins controller and datapath.
// Depends on sbd_pkg, sbd_ctrl and sbd_dp.
//
// Usage: spectrum bands enter on the s_ stream, one band per transfer in band
// order, s_tlast on the final band of a frame. Each band keeps a peak-hold
// level that decays along peak*(1-phase^3). On the last band one result
// leaves on the m_ stream: the mean held level of the enabled bands
// (m_tdata) and the beat flag (m_tuser). Other bands give no result.
// Registers are written on the cfg channel, which is always ready; write
// them only while the block is idle.
// Per band: read the band RAM, capture a new peak, hold at full decay, or
// run the square, cube and scale products and write back; a band past
// NUM_BANDS only counts. The last band adds the frame average, a 21-step
// bit-serial divider (none if no band is enabled), and any receiver wait.
// The decay cubic runs on one shared multiplier, one product per cycle.
// Reset clears all band state, the hold-off counter and the registers to
// their defaults. The result sits in an output register; while the receiver
// stalls the next frame's bands are still taken, and the block waits only
// when a second result would be ready.
`default_nettype none

module spectral_beat_detector #(
    parameter int NUM_BANDS = sbd_pkg::NUM_BANDS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,    // [15:0] band_level
    input  wire logic                           s_tlast,    // last_band
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [15:0]                    m_tdata,    // [15:0] average_level
    output logic      [0:0]                     m_tuser,    // [0] beat
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    sbd_pkg::t_dp_cmd    w_cmd;
    sbd_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    sbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sbd_dp #(
        .NUM_BANDS (NUM_BANDS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_band_level    (s_tdata),
        .i_last_band     (s_tlast),
        .i_out_ready     (m_tready),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_out_valid     (m_tvalid),
        .o_average_level (m_tdata),
        .o_beat          (m_tuser[0])
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sbd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the per-band state of the beat detector.
`default_nettype none

module sbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/sbd_ctrl.sv =====
// Controller state machine of the beat detector: sequences one band update,
// the frame average and the result. Depends on sbd_pkg.
`default_nettype none

module sbd_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sbd_pkg::t_dp_status i_status,
    output sbd_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_SQ,
        ST_MUL_CUBE,
        ST_MUL_SCALE,
        ST_WRITE,
        ST_ACC,
        ST_CHK,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd   = '0;
        o_cmd.mul = sbd_pkg::MUL_NONE;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    // A band past the last one only counts toward the frame end.
                    n_state = i_status.in_range ? ST_READ : ST_ACC;
                end
            end
            ST_READ: begin
                o_cmd.load_entry = 1'b1;
                priority if (i_status.bigger) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_ACC;
                end else if (i_status.phase_full) begin
                    n_state = ST_ACC;
                end else begin
                    n_state = ST_MUL_SQ;
                end
            end
            ST_MUL_SQ: begin
                o_cmd.mul = sbd_pkg::MUL_SQ;
                n_state = ST_MUL_CUBE;
            end
            ST_MUL_CUBE: begin
                o_cmd.mul = sbd_pkg::MUL_CUBE;
                n_state = ST_MUL_SCALE;
            end
            ST_MUL_SCALE: begin
                o_cmd.mul = sbd_pkg::MUL_SCALE;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write_decay = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.accumulate = 1'b1;
                n_state = i_status.last ? ST_CHK : ST_IDLE;
            end
            ST_CHK: begin
                if (i_status.count_zero) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sbd_dp.sv =====
// Datapath of the beat detector: configuration registers, band state RAM,
// shared multiplier, frame accumulator, serial divider and result register.
// Depends on sbd_pkg and sbd_ram.
`default_nettype none

module sbd_dp #(
    parameter int NUM_BANDS = sbd_pkg::NUM_BANDS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [sbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sbd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [sbd_pkg::LVL_W-1:0]        i_band_level,
    input  wire logic                             i_last_band,
    input  wire logic                             i_out_ready,
    input  wire sbd_pkg::t_dp_cmd                 i_cmd,
    output sbd_pkg::t_dp_status                   o_status,
    output logic                                  o_out_valid,
    output logic      [sbd_pkg::LVL_W-1:0]        o_average_level,
    output logic                                  o_beat
);

    localparam int ADDR_W = $clog2(NUM_BANDS);
    localparam int POS_W  = $clog2(NUM_BANDS + 1);
    localparam int LW     = sbd_pkg::LVL_W;
    localparam int PW     = sbd_pkg::PHASE_W;
    localparam int CW     = sbd_pkg::CNT_W;
    localparam int SW     = sbd_pkg::SUM_W;

    // Configuration
    logic [LW-1:0]                  r_decay_step;
    logic [LW-1:0]                  r_beat_threshold;
    logic [sbd_pkg::HOLD_W-1:0]     r_holdoff_count;
    logic [sbd_pkg::MASK_W-1:0]     r_band_enable_mask;

    // Frame and band control state
    logic [POS_W-1:0]               r_pos;
    logic [SW-1:0]                  r_sum;
    logic [CW-1:0]                  r_count;
    logic [sbd_pkg::HOLD_W-1:0]     r_holdoff;
    logic [NUM_BANDS-1:0]           r_valid;
    logic                           r_out_valid;

    // Working registers of one item
    logic [LW-1:0]                  r_lvl;
    logic                           r_last;
    logic                           r_upd;
    logic                           r_vld_rd;
    logic [LW-1:0]                  r_held_cur;
    logic [LW-1:0]                  r_peak;
    logic [PW-1:0]                  r_p;
    logic [sbd_pkg::PROD_W-1:0]     r_prod;
    logic [SW-1:0]                  r_quo;
    logic [CW-1:0]                  r_rem;
    logic [sbd_pkg::DSTEP_W-1:0]    r_dstep;
    logic [LW-1:0]                  r_avg;
    logic                           r_beat;

    logic                           w_in_range;
    logic [ADDR_W-1:0]              w_idx;
    logic [sbd_pkg::ENTRY_W-1:0]    w_rdata;
    logic [sbd_pkg::ENTRY_W-1:0]    w_wdata;
    logic                           w_we;
    logic [LW-1:0]                  w_held_rd;
    logic [LW-1:0]                  w_peak_rd;
    logic [PW-1:0]                  w_phase_rd;
    logic [PW:0]                    w_p_sum;
    logic [PW-1:0]                  w_p_next;
    logic                           w_bigger;
    logic [PW-1:0]                  w_mul_a;
    logic [PW-1:0]                  w_mul_b;
    logic [sbd_pkg::PROD_W-1:0]     w_prod;
    logic [LW-1:0]                  w_held_new;
    logic                           w_enabled;
    logic [CW:0]                    w_trial;
    logic [CW:0]                    w_diff;
    logic                           w_ge;
    logic                           w_count_zero;
    logic [LW-1:0]                  w_avg;
    logic                           w_over;

    assign w_in_range = (r_pos < POS_W'(NUM_BANDS));
    assign w_idx      = r_pos[ADDR_W-1:0];

    // Entries never written since reset read as zero.
    assign w_held_rd  = r_vld_rd ? w_rdata[LW-1:0]      : '0;
    assign w_peak_rd  = r_vld_rd ? w_rdata[2*LW-1:LW]   : '0;
    assign w_phase_rd = r_vld_rd ? w_rdata[2*LW+PW-1:2*LW] : '0;

    assign w_bigger = (r_lvl > w_held_rd);
    assign w_p_sum  = {1'b0, w_phase_rd} + {{(PW + 1 - LW){1'b0}}, r_decay_step};
    assign w_p_next = (w_p_sum > {1'b0, sbd_pkg::ONE_Q16}) ? sbd_pkg::ONE_Q16 : w_p_sum[PW-1:0];

    always_comb begin
        unique case (i_cmd.mul)
            sbd_pkg::MUL_SQ: begin
                w_mul_a = r_p;
                w_mul_b = r_p;
            end
            sbd_pkg::MUL_CUBE: begin
                w_mul_a = r_prod[PW+15:16];
                w_mul_b = r_p;
            end
            sbd_pkg::MUL_SCALE: begin
                w_mul_a = {1'b0, r_peak};
                w_mul_b = sbd_pkg::ONE_Q16 - r_prod[PW+15:16];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_held_new = r_prod[LW+15:16];

    assign w_we    = i_cmd.capture | i_cmd.write_decay;
    assign w_wdata = i_cmd.capture ? {{PW{1'b0}}, r_lvl, r_lvl}
                                   : {r_p, r_peak, w_held_new};

    // Only the first 32 bands have an enable bit.
    assign w_enabled = r_upd && (32'(r_pos) < 32'd32) && r_band_enable_mask[r_pos[4:0]];

    assign w_trial = {r_rem, r_quo[SW-1]};
    assign w_diff  = w_trial - {1'b0, r_count};
    assign w_ge    = (w_trial >= {1'b0, r_count});

    assign w_count_zero = (r_count == '0);
    assign w_avg        = w_count_zero ? '0 : r_quo[LW-1:0];
    assign w_over       = !w_count_zero && (w_avg >= r_beat_threshold);

    sbd_ram #(
        .WIDTH (sbd_pkg::ENTRY_W),
        .DEPTH (NUM_BANDS)
    ) u_band_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.accept && w_in_range),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_step       <= sbd_pkg::DECAY_STEP_RST;
            r_beat_threshold   <= sbd_pkg::BEAT_THRESHOLD_RST;
            r_holdoff_count    <= sbd_pkg::HOLDOFF_COUNT_RST;
            r_band_enable_mask <= sbd_pkg::BAND_ENABLE_RST;
            r_pos              <= '0;
            r_sum              <= '0;
            r_count            <= '0;
            r_holdoff          <= '0;
            r_valid            <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (sbd_pkg::t_cfg_idx'(i_cfg_index))
                    sbd_pkg::CFG_DECAY_STEP:     r_decay_step       <= i_cfg_data[LW-1:0];
                    sbd_pkg::CFG_BEAT_THRESHOLD: r_beat_threshold   <= i_cfg_data[LW-1:0];
                    sbd_pkg::CFG_HOLDOFF_COUNT:  r_holdoff_count    <= i_cfg_data[sbd_pkg::HOLD_W-1:0];
                    sbd_pkg::CFG_BAND_ENABLE:    r_band_enable_mask <= i_cfg_data[sbd_pkg::MASK_W-1:0];
                    default: ;
                endcase
            end
            if (w_we) begin
                r_valid[w_idx] <= 1'b1;
            end
            if (i_cmd.accumulate) begin
                if (w_enabled) begin
                    r_sum   <= r_sum + {{(SW - LW){1'b0}}, r_held_cur};
                    r_count <= r_count + 1'b1;
                end
                if (r_upd) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_pos   <= '0;
                r_sum   <= '0;
                r_count <= '0;
                if (w_over) begin
                    r_holdoff <= (r_holdoff == '0) ? r_holdoff_count : r_holdoff - 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lvl    <= i_band_level;
            r_last   <= i_last_band;
            r_upd    <= w_in_range;
            r_vld_rd <= w_in_range && r_valid[w_idx];
        end
        if (i_cmd.load_entry) begin
            r_held_cur <= w_bigger ? r_lvl : w_held_rd;
            r_peak     <= w_peak_rd;
            r_p        <= w_p_next;
        end
        if (i_cmd.mul != sbd_pkg::MUL_NONE) begin
            r_prod <= w_prod;
        end
        if (i_cmd.write_decay) begin
            r_held_cur <= w_held_new;
        end
        if (i_cmd.div_start) begin
            r_quo   <= r_sum;
            r_rem   <= '0;
            r_dstep <= '0;
        end else if (i_cmd.div_step) begin
            r_rem   <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
            r_quo   <= {r_quo[SW-2:0], w_ge};
            r_dstep <= r_dstep + 1'b1;
        end
        if (i_cmd.finish) begin
            r_avg  <= w_avg;
            r_beat <= w_over && (r_holdoff == '0);
        end
    end

    always_comb begin
        o_status.in_range   = w_in_range;
        o_status.bigger     = w_bigger;
        o_status.phase_full = (w_phase_rd >= sbd_pkg::ONE_Q16);
        o_status.last       = r_last;
        o_status.count_zero = w_count_zero;
        o_status.div_last   = (r_dstep == sbd_pkg::DSTEP_W'(SW - 1));
        o_status.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_average_level = r_avg;
    assign o_beat          = r_beat;

endmodule

`default_nettype wire

// ===== hw/rtl/sbd_checker.sv =====
// Port-level checks for the spectral beat detector, bound to the top level.
// Depends on sbd_pkg.
`default_nettype none

module sbd_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [15:0]                    m_tdata,
    input wire logic [0:0]                     m_tuser,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [sbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Shadow of the beat threshold as written on the configuration channel.
    logic [15:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= sbd_pkg::BEAT_THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready
                     && i_cfg_index == sbd_pkg::CFG_BEAT_THRESHOLD) begin
            r_thr <= i_cfg_data[15:0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("band taken while the previous one is still in work");

    a_beat_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata >= r_thr)
        else $error("beat flagged below the threshold");

endmodule

bind spectral_beat_detector sbd_checker u_sbd_checker (.*);

`default_nettype wire

// ===== sim/spectral_beat_detector_tb.sv =====
// Self-checking testbench for spectral_beat_detector: streams spectrum frames,
// writes the registers between phases, predicts each frame's average and beat.
// Depends on sbd_pkg and the spectral_beat_detector RTL.
module spectral_beat_detector_tb;

    localparam int BANDS         = sbd_pkg::NUM_BANDS_DEF;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [15:0] average;
        logic        beat;
    } t_frame_result;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata     = '0;
    logic                           s_tlast     = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [15:0]                    m_tdata;
    logic [0:0]                     m_tuser;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    sbd_pkg::t_cfg_idx              i_cfg_index = sbd_pkg::CFG_DECAY_STEP;
    logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Register copies and band state of the predictor.
    logic [15:0]      step_reg      = sbd_pkg::DECAY_STEP_RST;
    logic [15:0]      threshold_reg = sbd_pkg::BEAT_THRESHOLD_RST;
    logic [7:0]       holdoff_reg   = sbd_pkg::HOLDOFF_COUNT_RST;
    logic [31:0]      mask_reg      = sbd_pkg::BAND_ENABLE_RST;
    logic [15:0]      held [BANDS];
    logic [15:0]      peak [BANDS];
    logic [16:0]      phase [BANDS];
    int               band_pos      = 0;
    logic [20:0]      sum_acc       = '0;
    logic [5:0]       count_acc     = '0;
    logic [7:0]       holdoff_left  = '0;

    t_frame_result    frame_results_q [$];
    t_frame_result    checked_entry;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int bands_sent    = 0;
    int frames_seen   = 0;
    int beats_seen    = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;

    spectral_beat_detector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // [15:0] band_level
        .s_tlast     (s_tlast),      // last_band
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // [15:0] average_level
        .m_tuser     (m_tuser),      // [0] beat
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Applies one band to the peak-hold state and, on the last band, queues
    // the frame result.
    task automatic track_band(input logic [15:0] lvl, input logic last);
        logic [17:0]   p;
        logic [63:0]   pw;
        logic [63:0]   p2;
        logic [63:0]   p3;
        logic [63:0]   scaled;
        t_frame_result res;
        if (band_pos < BANDS) begin
            if (lvl > held[band_pos]) begin
                held[band_pos]  = lvl;
                peak[band_pos]  = lvl;
                phase[band_pos] = '0;
            end else if (phase[band_pos] < sbd_pkg::ONE_Q16) begin
                p = 18'(phase[band_pos]) + 18'(step_reg);
                if (p > 18'(sbd_pkg::ONE_Q16)) begin
                    p = 18'(sbd_pkg::ONE_Q16);
                end
                phase[band_pos] = p[16:0];
                pw = 64'(p);
                p2 = (pw * pw) >> 16;
                p3 = (p2 * pw) >> 16;
                if (p3 > 64'(sbd_pkg::ONE_Q16)) begin
                    p3 = 64'(sbd_pkg::ONE_Q16);
                end
                scaled = 64'(peak[band_pos]);
                scaled = (scaled * (64'(sbd_pkg::ONE_Q16) - p3)) >> 16;
                held[band_pos] = scaled[15:0];
            end
            if (mask_reg[band_pos]) begin
                sum_acc   = sum_acc + 21'(held[band_pos]);
                count_acc = count_acc + 1'b1;
            end
            band_pos++;
        end
        if (last) begin
            res = '0;
            if (count_acc != 0) begin
                res.average = 16'(sum_acc / count_acc);
                if (res.average >= threshold_reg) begin
                    if (holdoff_left == 0) begin
                        res.beat     = 1'b1;
                        holdoff_left = holdoff_reg;
                    end else begin
                        holdoff_left = holdoff_left - 1'b1;
                    end
                end
            end
            band_pos  = 0;
            sum_acc   = '0;
            count_acc = '0;
            frame_results_q.push_back(res);
        end
    endtask

    // Offers one band; valid stays high after the transfer until the next
    // falling edge, where the next call or idle_sender decides its value.
    task automatic send_band(input logic [15:0] lvl, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lvl;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        track_band(lvl, last);
        bands_sent++;
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        idle_sender();
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input sbd_pkg::t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sbd_pkg::CFG_DECAY_STEP:     step_reg      = val[15:0];
            sbd_pkg::CFG_BEAT_THRESHOLD: threshold_reg = val[15:0];
            sbd_pkg::CFG_HOLDOFF_COUNT:  holdoff_reg   = val[7:0];
            sbd_pkg::CFG_BAND_ENABLE:    mask_reg      = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_frame();
        int          pick;
        int          len;
        logic [15:0] lvl;
        pick = $urandom_range(99);
        if (pick < 55) begin
            len = BANDS;
        end else if (pick < 75) begin
            len = $urandom_range(1, BANDS - 1);
        end else if (pick < 85) begin
            len = $urandom_range(BANDS + 1, BANDS + 8);
        end else begin
            len = $urandom_range(2, 10);
        end
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0:       lvl = 16'h0000;
                1:       lvl = 16'hFFFF;
                2, 3, 4: lvl = 16'($urandom);
                default: lvl = 16'($urandom_range(16'h4000, 16'hFFFF));
            endcase
            send_band(lvl, i == len - 1);
        end
    endtask

    task automatic randomize_config();
        logic [15:0] step_val;
        logic [15:0] thr_val;
        logic [7:0]  hold_val;
        logic [31:0] mask_val;
        case ($urandom_range(3))
            0:       step_val = 16'h0000;
            1:       step_val = 16'hFFFF;
            2:       step_val = 16'($urandom_range(1, 3000));
            default: step_val = 16'($urandom);
        endcase
        case ($urandom_range(3))
            0:       thr_val = 16'h0000;
            1:       thr_val = 16'hFFFF;
            2:       thr_val = 16'($urandom_range(0, 16'h5000));
            default: thr_val = 16'($urandom);
        endcase
        case ($urandom_range(3))
            0:       hold_val = 8'd0;
            1:       hold_val = 8'd255;
            default: hold_val = 8'($urandom_range(0, 4));
        endcase
        case ($urandom_range(4))
            0:       mask_val = 32'hFFFF_FFFF;
            1:       mask_val = 32'h0000_0000;
            2:       mask_val = 32'd1 << $urandom_range(31);
            3:       mask_val = $urandom & $urandom;
            default: mask_val = $urandom;
        endcase
        write_reg(sbd_pkg::CFG_DECAY_STEP, {16'h0, step_val});
        write_reg(sbd_pkg::CFG_BEAT_THRESHOLD, {16'h0, thr_val});
        write_reg(sbd_pkg::CFG_HOLDOFF_COUNT, {24'h0, hold_val});
        write_reg(sbd_pkg::CFG_BAND_ENABLE, mask_val);
    endtask

    // Default registers enable no band, so the frame averages to zero.
    task automatic test_reset_defaults();
        send_band(16'h1234, 1'b0);
        send_band(16'hFFFF, 1'b0);
        send_band(16'h0000, 1'b1);
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        write_reg(sbd_pkg::CFG_DECAY_STEP, 32'h0000_FFFF);
        write_reg(sbd_pkg::CFG_BEAT_THRESHOLD, 32'h0000_0000);
        write_reg(sbd_pkg::CFG_HOLDOFF_COUNT, 32'd2);
        write_reg(sbd_pkg::CFG_BAND_ENABLE, 32'hFFFF_FFFF);
        // Capture, then two decaying frames that count the hold-off down,
        // then full-scale peaks that fire again.
        send_band(16'hFFFF, 1'b0);
        send_band(16'h0000, 1'b0);
        send_band(16'h8000, 1'b0);
        send_band(16'h0001, 1'b1);
        repeat (2) begin
            repeat (3) send_band(16'h0000, 1'b0);
            send_band(16'h0000, 1'b1);
        end
        repeat (3) send_band(16'hFFFF, 1'b0);
        send_band(16'hFFFF, 1'b1);
        wait_drained();
        // Zero step keeps the held level at the peak; short frames only
        // average the bands they reach.
        write_reg(sbd_pkg::CFG_DECAY_STEP, 32'h0000_0000);
        write_reg(sbd_pkg::CFG_BEAT_THRESHOLD, 32'h0000_FFFF);
        write_reg(sbd_pkg::CFG_BAND_ENABLE, 32'h0000_0005);
        send_band(16'h0000, 1'b1);
        send_band(16'h8000, 1'b0);
        send_band(16'h0001, 1'b0);
        send_band(16'hFFFF, 1'b1);
        wait_drained();
    endtask

    // The receiver holds off long enough that the block fills and stalls
    // its input while the sender keeps offering bands.
    task automatic test_receiver_backpressure();
        write_reg(sbd_pkg::CFG_DECAY_STEP, 32'd1200);
        write_reg(sbd_pkg::CFG_BEAT_THRESHOLD, 32'h0000_2000);
        write_reg(sbd_pkg::CFG_BAND_ENABLE, 32'hFFFF_FFFF);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 800;
        repeat (3) begin
            for (int i = 0; i < BANDS; i++) begin
                send_band(16'($urandom), i == BANDS - 1);
            end
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input int budget);
        int start;
        start         = bands_sent;
        send_idle_pct = sender_idle;
        stall_pct     = receiver_stall;
        while (bands_sent - start < budget) begin
            wait_drained();
            randomize_config();
            repeat ($urandom_range(2, 4)) send_random_frame();
        end
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (frame_results_q.size() == 0) begin
                $display("%0t: result with none pending: average %h beat %b",
                         $time, m_tdata, m_tuser[0]);
                errors++;
            end else begin
                checked_entry = frame_results_q.pop_front();
                frames_seen++;
                if (checked_entry.beat) begin
                    beats_seen++;
                end
                if (m_tdata !== checked_entry.average) begin
                    $display("%0t: average_level expected %h, got %h",
                             $time, checked_entry.average, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== checked_entry.beat) begin
                    $display("%0t: beat expected %b, got %b",
                             $time, checked_entry.beat, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results pending",
                     $time, cycle_count, frame_results_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < BANDS; i++) begin
            held[i]  = '0;
            peak[i]  = '0;
            phase[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_extremes();
        test_receiver_backpressure();
        test_random_traffic(0, 0, 100);
        test_random_traffic(85, 0, 100);
        test_random_traffic(0, 85, 100);
        test_random_traffic(13, 13, 100);

        $display("Sent %0d bands; checked %0d frame results with %0d beats.",
                 bands_sent, frames_seen, beats_seen);
        $display("Made %0d register writes over directed, stalled and random phases.",
                 reg_writes);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== spectral_beat_detector.f =====
hw/rtl/sbd_pkg.sv
hw/rtl/sbd_ram.sv
hw/rtl/sbd_ctrl.sv
hw/rtl/sbd_dp.sv
hw/rtl/spectral_beat_detector.sv
hw/rtl/sbd_checker.sv
sim/spectral_beat_detector_tb.sv
